### rtl/dcrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Display command register port package
// Access codes, command codes, mode tables and shared types.
// ----------------------------------------------------------------------------
package dcrp_pkg;

    localparam int DATA_W = 16;
    localparam int COL_W  = 9;
    localparam int ROW_W  = 8;
    localparam int MODE_W = 3;
    localparam int BYTE_W = 8;
    localparam int DVS_W  = 9;

    localparam logic [2:0] OP_READ_LO  = 3'd0;
    localparam logic [2:0] OP_READ_HI  = 3'd1;
    localparam logic [2:0] OP_WRITE_LO = 3'd2;
    localparam logic [2:0] OP_WRITE_HI = 3'd3;
    localparam logic [2:0] OP_COMMAND  = 3'd4;

    localparam logic [7:0] CMD_GET_SIZE   = 8'd0;
    localparam logic [7:0] CMD_GET_WIDTH  = 8'd1;
    localparam logic [7:0] CMD_GET_HEIGHT = 8'd2;
    localparam logic [7:0] CMD_GET_MODE   = 8'd3;
    localparam logic [7:0] CMD_GET_INDEX  = 8'd4;
    localparam logic [7:0] CMD_GET_X      = 8'd5;
    localparam logic [7:0] CMD_GET_Y      = 8'd6;
    localparam logic [7:0] CMD_GET_TYPE   = 8'd7;
    localparam logic [7:0] CMD_SET_MODE   = 8'd8;
    localparam logic [7:0] CMD_SET_INDEX  = 8'd9;
    localparam logic [7:0] CMD_SET_X      = 8'd10;
    localparam logic [7:0] CMD_SET_Y      = 8'd11;
    localparam logic [7:0] CMD_SET_POS    = 8'd12;
    localparam logic [7:0] CMD_SET_TYPE   = 8'd13;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV1 = 4'b0010,
        ST_DIV2 = 4'b0100,
        ST_LINK = 4'b1000
    } seq_state_t;

    typedef struct packed {
        logic                start;
        logic [DATA_W-1:0]   dividend;
        logic [DVS_W-1:0]    divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [DATA_W-1:0]   quotient;
        logic [DVS_W-1:0]    remainder;
    } div_rsp_t;

    function automatic logic [DATA_W-1:0] mode_size(input logic [MODE_W-1:0] m);
        logic [DATA_W-1:0] r;
        case (m)
            3'd0: r = 16'd1000;
            3'd1: r = 16'd2000;
            3'd2: r = 16'd4000;
            3'd3: r = 16'd8000;
            3'd4: r = 16'd8000;
            3'd5: r = 16'd32000;
            3'd6: r = 16'd8000;
            default: r = 16'd32000;
        endcase
        return r;
    endfunction

    function automatic logic [COL_W-1:0] mode_width(input logic [MODE_W-1:0] m);
        logic [COL_W-1:0] r;
        case (m)
            3'd0, 3'd1: r = 9'd40;
            3'd2, 3'd3: r = 9'd80;
            default: r = 9'd320;
        endcase
        return r;
    endfunction

    function automatic logic [ROW_W-1:0] mode_height(input logic [MODE_W-1:0] m);
        logic [ROW_W-1:0] r;
        case (m)
            3'd0, 3'd1: r = 8'd25;
            3'd2, 3'd3: r = 8'd50;
            default: r = 8'd200;
        endcase
        return r;
    endfunction

endpackage

### rtl/display_command_register_port_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Display command register port
// Byte access port to the data register, mode and cursor of a display.
// ----------------------------------------------------------------------------
// The s_ channel carries one access per transaction: s_op selects a read of
// the low or high data byte, a write of either byte, or a command in s_value.
// Every accepted transaction gives exactly one m_ transaction; m_read_byte is
// the selected byte for reads and zero otherwise.
// The result is registered at the accepting edge, so m_valid rises in the
// cycle after acceptance. Reads, writes, get commands and set mode or set
// type leave the sequencer idle. Cursor set commands run the serial divider,
// once for set x and set y and twice for set position and set index,
// followed by a link state that rebuilds the linear index before the next
// access is taken.
// A new access is taken only while the sequencer is idle and the result
// register is empty or being drained in the same cycle, so a stalled
// receiver holds off the sender. Reset clears the data register, mode,
// cursor and style to zero and empties the result register.
// ----------------------------------------------------------------------------
module display_command_register_port_top
    import dcrp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_op,
    input  logic [7:0] s_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_byte
);

    seq_state_t        state_reg, state_next;
    logic [DATA_W-1:0] data_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [COL_W-1:0]  cursor_col_reg;
    logic [ROW_W-1:0]  cursor_row_reg;
    logic [DATA_W-1:0] cursor_linear_reg;
    logic [BYTE_W-1:0] cursor_style_reg;
    logic              m_valid_reg;
    logic [BYTE_W-1:0] m_read_byte_reg;
    logic [7:0]        cmd_reg;

    logic              accept;
    logic              is_cmd;
    logic              div_cmd;
    logic [COL_W-1:0]  width;
    logic [ROW_W-1:0]  height;
    logic [DATA_W-1:0] link_sum;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    assign width   = mode_width(mode_reg);
    assign height  = mode_height(mode_reg);
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign is_cmd  = s_op == OP_COMMAND;
    assign div_cmd = is_cmd && (s_value == CMD_SET_INDEX || s_value == CMD_SET_X ||
                                s_value == CMD_SET_Y || s_value == CMD_SET_POS);
    assign link_sum = {8'd0, cursor_row_reg} * {7'd0, width} + {7'd0, cursor_col_reg};

    always_comb begin
        div_req = '0;
        if (state_reg == ST_IDLE && accept && div_cmd) begin
            div_req.start = 1'b1;
            if (s_value == CMD_SET_INDEX) begin
                div_req.dividend = data_reg;
            end else begin
                div_req.dividend = {8'd0, data_reg[7:0]};
            end
            if (s_value == CMD_SET_Y) begin
                div_req.divisor = {1'b0, height};
            end else begin
                div_req.divisor = width;
            end
        end else if (state_reg == ST_DIV1 && div_rsp.done &&
                     (cmd_reg == CMD_SET_INDEX || cmd_reg == CMD_SET_POS)) begin
            div_req.start   = 1'b1;
            div_req.divisor = {1'b0, height};
            if (cmd_reg == CMD_SET_INDEX) begin
                div_req.dividend = div_rsp.quotient;
            end else begin
                div_req.dividend = {8'd0, data_reg[15:8]};
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && div_cmd) begin
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1: begin
                if (div_rsp.done) begin
                    state_next = div_req.start ? ST_DIV2 : ST_LINK;
                end
            end
            ST_DIV2: begin
                if (div_rsp.done) begin
                    state_next = ST_LINK;
                end
            end
            ST_LINK: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            data_reg          <= '0;
            mode_reg          <= '0;
            cursor_col_reg    <= '0;
            cursor_row_reg    <= '0;
            cursor_linear_reg <= '0;
            cursor_style_reg  <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
                case (s_op)
                    OP_WRITE_LO: data_reg[7:0]  <= s_value;
                    OP_WRITE_HI: data_reg[15:8] <= s_value;
                    OP_COMMAND: begin
                        case (s_value)
                            CMD_GET_SIZE:   data_reg <= mode_size(mode_reg);
                            CMD_GET_WIDTH:  data_reg <= {7'd0, width};
                            CMD_GET_HEIGHT: data_reg <= {8'd0, height};
                            CMD_GET_MODE:   data_reg <= {5'd0, mode_reg, 5'd0, mode_reg};
                            CMD_GET_INDEX:  data_reg <= cursor_linear_reg;
                            CMD_GET_X:      data_reg <= {7'd0, cursor_col_reg};
                            CMD_GET_Y:      data_reg <= {cursor_row_reg, cursor_row_reg};
                            CMD_GET_TYPE:   data_reg <= {cursor_style_reg, cursor_style_reg};
                            CMD_SET_MODE:   mode_reg <= data_reg[MODE_W-1:0];
                            CMD_SET_TYPE:   cursor_style_reg <= data_reg[7:0];
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_DIV1: begin
                    if (div_rsp.done) begin
                        if (cmd_reg == CMD_SET_Y) begin
                            cursor_row_reg <= div_rsp.remainder[ROW_W-1:0];
                        end else begin
                            cursor_col_reg <= div_rsp.remainder;
                        end
                    end
                end
                ST_DIV2: begin
                    if (div_rsp.done) begin
                        cursor_row_reg <= div_rsp.remainder[ROW_W-1:0];
                    end
                end
                ST_LINK: cursor_linear_reg <= link_sum;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= s_value;
            case (s_op)
                OP_READ_LO: m_read_byte_reg <= data_reg[7:0];
                OP_READ_HI: m_read_byte_reg <= data_reg[15:8];
                default:    m_read_byte_reg <= '0;
            endcase
        end
    end

    dcrp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign m_valid     = m_valid_reg;
    assign m_read_byte = m_read_byte_reg;

endmodule

### rtl/dcrp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dcrp_div
    import dcrp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [3:0]        cnt_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DVS_W-1:0]  dvs_reg;

    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;
    logic              fits;
    logic [DVS_W-1:0]  rem_next;

    assign trial    = {rem_reg, quo_reg[DATA_W-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign fits     = !diff[DVS_W];
    assign rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= !req.start && busy_reg && cnt_reg == 4'd15;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == 4'd15) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            cnt_reg <= 4'd0;
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 4'd1;
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DATA_W-2:0], fits};
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

### rtl/dcrp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Display command register port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module dcrp_checker
    import dcrp_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [2:0] s_op,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_read_byte
);

    // Every accepted access produces a result in the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted transaction gave no result");

    // Writes and commands always return a zero byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op != OP_READ_LO && s_op != OP_READ_HI
        |=> m_read_byte == 8'd0)
        else $error("non-read transaction returned a nonzero byte");

    // A pending result blocks new input until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while a result was stalled");

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_byte))
        else $error("stalled result changed");

endmodule

bind display_command_register_port_top dcrp_checker u_dcrp_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_op        (s_op),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_read_byte (m_read_byte)
);
